FILE: rtl/u8dv_pkg.sv
// ============================================================================
// u8dv_pkg - shared types and constants
// Word types, lead classification and code point limits for the UTF-8
// stream decoder / validator.
// ============================================================================
package u8dv_pkg;

   // Queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Pending window of the decoder
   localparam int PendDepth = 4;

   // Validation modes
   localparam logic MODE_UTF8 = 1'b0;
   localparam logic MODE_WTF8 = 1'b1;

   // Code point constants
   localparam logic [20:0] CP_REPL     = 21'h00FFFD;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] CP_MIN_2B   = 21'h000080;
   localparam logic [20:0] CP_MIN_3B   = 21'h000800;
   localparam logic [20:0] CP_MIN_4B   = 21'h010000;
   localparam logic [20:0] CP_SUR_LO   = 21'h00D800;
   localparam logic [20:0] CP_HSUR_HI  = 21'h00DBFF;
   localparam logic [20:0] CP_LSUR_LO  = 21'h00DC00;
   localparam logic [20:0] CP_SUR_HI   = 21'h00DFFF;

   // Sequence lengths given by a lead byte (zero = bad lead)
   localparam logic [2:0] LEN_BAD = 3'd0;
   localparam logic [2:0] LEN_1   = 3'd1;
   localparam logic [2:0] LEN_2   = 3'd2;
   localparam logic [2:0] LEN_3   = 3'd3;
   localparam logic [2:0] LEN_4   = 3'd4;

   // A classified byte
   typedef struct packed {
      logic [7:0] data;
      logic [2:0] lead_len;
      logic       is_cont;
   } u8dv_byte_type;

   // One queue word: classified byte plus end of string
   typedef struct packed {
      u8dv_byte_type b;
      logic          eos;
   } u8dv_item_type;

   // Result word as held in the output register
   typedef struct packed {
      logic [20:0] codepoint;
      logic [2:0]  byte_count;
      logic        malformed;
      logic        string_valid;
      logic        string_end;
      logic        last_of_run;
   } u8dv_result_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = LEN_BAD;
      if (b[7] == 1'b0)            len = LEN_1;
      else if (b[7:5] == 3'b110)   len = LEN_2;
      else if (b[7:4] == 4'b1110)  len = LEN_3;
      else if (b[7:3] == 5'b11110) len = LEN_4;
      return len;
   endfunction

endpackage

FILE: rtl/u8dv_front.sv
// ============================================================================
// u8dv_front - input stage
// Accepts request words, classifies the byte and hands it to the queue.
// ============================================================================
module u8dv_front
   import u8dv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   output logic          push_valid,
   output u8dv_item_type push_item,
   input  logic          push_ready
);

   logic          vld_ff, vld_in;
   u8dv_item_type item_ff, item_in;
   logic          req_acc;

   assign req_tready = !vld_ff || push_ready;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      item_in            = item_ff;
      vld_in             = vld_ff;
      if (req_acc) begin
         item_in.b.data     = req_tdata;
         item_in.b.lead_len = lead_length(req_tdata);
         item_in.b.is_cont  = (req_tdata[7:6] == 2'b10);
         item_in.eos        = req_tlast;
         vld_in             = 1'b1;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = vld_ff;
   assign push_item  = item_ff;

endmodule

FILE: rtl/u8dv_queue.sv
// ============================================================================
// u8dv_queue - classified byte queue
// Small FIFO that decouples the input stage from the decoder.
// ============================================================================
module u8dv_queue
   import u8dv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  u8dv_item_type push_item,
   output logic          push_ready,
   output logic          pop_valid,
   output u8dv_item_type pop_item,
   input  logic          pop_en
);

   u8dv_item_type          entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign push_ready = (cnt_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_en && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/u8dv_back.sv
// ============================================================================
// u8dv_back - decoder and validator
// Keeps the pending window, decodes one head sequence per cycle while the
// result register is free, and drives the result register.
// ============================================================================
module u8dv_back
   import u8dv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            mode,
   input  logic            pop_valid,
   input  u8dv_item_type   pop_item,
   output logic            pop_en,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output u8dv_result_type rsp_word
);

   u8dv_byte_type   pend_ff  [PendDepth];
   u8dv_byte_type   pend_in  [PendDepth];
   logic [2:0]      cnt_ff, cnt_in;
   logic            eos_ff, eos_in;
   logic            busy_ff, busy_in;
   logic            valid_ff, valid_in;
   logic            prev_hs_ff, prev_hs_in;
   logic            out_vld_ff, out_vld_in;
   u8dv_result_type out_ff, out_in;

   u8dv_byte_type   view   [PendDepth];
   u8dv_byte_type   shifted[PendDepth];
   u8dv_byte_type   next_head;
   logic [2:0]      view_cnt, len, used, rem, sidx;
   logic            view_eos, take, can_dec, out_free, fire;
   logic            bad, cont_bad, is_last, sur, hsur, lsur, vflag;
   logic [20:0]     raw_cp, cp;

   assign take     = !busy_ff && pop_valid;
   assign pop_en   = take;
   assign out_free = !out_vld_ff || rsp_ready;

   // Working window: pending bytes, plus the incoming byte when one is taken
   always_comb begin
      for (int j = 0; j < PendDepth; j++) view[j] = pend_ff[j];
      view_cnt = cnt_ff;
      view_eos = eos_ff;
      if (take) begin
         view[cnt_ff[1:0]] = pop_item.b;
         view_cnt          = cnt_ff + 3'd1;
         view_eos          = pop_item.eos;
      end
   end

   assign len     = view[0].lead_len;
   assign can_dec = (view_cnt != 3'd0) &&
                    ((len == LEN_BAD) || (len <= view_cnt) || view_eos);
   assign fire    = can_dec && out_free;

   // Head decode
   always_comb begin
      case (len)
         LEN_1:   raw_cp = {13'd0, view[0].data};
         LEN_2:   raw_cp = {10'd0, view[0].data[4:0], view[1].data[5:0]};
         LEN_3:   raw_cp = {5'd0, view[0].data[3:0], view[1].data[5:0],
                            view[2].data[5:0]};
         LEN_4:   raw_cp = {view[0].data[2:0], view[1].data[5:0],
                            view[2].data[5:0], view[3].data[5:0]};
         default: raw_cp = CP_REPL;
      endcase

      used     = len;
      cont_bad = 1'b0;
      for (int i = 1; i < PendDepth; i++) begin
         if (!cont_bad && (3'(i) < len) && !view[i].is_cont) begin
            cont_bad = 1'b1;
            used     = 3'(i);
         end
      end

      bad = 1'b0;
      if ((len == LEN_BAD) || (len > view_cnt)) begin
         bad  = 1'b1;
         used = 3'd1;
      end else if (cont_bad) begin
         bad = 1'b1;
      end else if (((len == LEN_2) && (raw_cp < CP_MIN_2B)) ||
                   ((len == LEN_3) && (raw_cp < CP_MIN_3B)) ||
                   ((len == LEN_4) && (raw_cp < CP_MIN_4B)) ||
                   (raw_cp > CP_MAX)) begin
         bad = 1'b1;
      end
      cp = bad ? CP_REPL : raw_cp;
   end

   // Validity tracking
   always_comb begin
      sur   = (cp >= CP_SUR_LO) && (cp <= CP_SUR_HI);
      hsur  = (cp >= CP_SUR_LO) && (cp <= CP_HSUR_HI);
      lsur  = (cp >= CP_LSUR_LO) && (cp <= CP_SUR_HI);
      vflag = valid_ff;
      if (bad)                                         vflag = 1'b0;
      else if ((mode == MODE_UTF8) && sur)             vflag = 1'b0;
      else if ((mode == MODE_WTF8) && prev_hs_ff && lsur) vflag = 1'b0;
   end

   // Window after consuming the head, and whether this result ends the run
   always_comb begin
      rem = view_cnt - used;
      for (int j = 0; j < PendDepth; j++) begin
         sidx = 3'(j) + used;
         shifted[j] = (sidx < 3'(PendDepth)) ? view[sidx[1:0]] : view[j];
      end
      next_head = view[used[1:0]];
      if (view_eos) begin
         is_last = (rem == 3'd0);
      end else begin
         is_last = (rem == 3'd0) ||
                   ((next_head.lead_len != LEN_BAD) && (next_head.lead_len > rem));
      end
   end

   // Next state
   always_comb begin
      for (int j = 0; j < PendDepth; j++) pend_in[j] = pend_ff[j];
      cnt_in     = cnt_ff;
      eos_in     = take ? view_eos : eos_ff;
      busy_in    = busy_ff;
      valid_in   = valid_ff;
      prev_hs_in = prev_hs_ff;
      out_in     = out_ff;
      out_vld_in = rsp_ready ? 1'b0 : out_vld_ff;

      if (fire) begin
         for (int j = 0; j < PendDepth; j++) pend_in[j] = shifted[j];
         cnt_in     = rem;
         busy_in    = !is_last;
         valid_in   = vflag;
         prev_hs_in = !bad && hsur;
         if (is_last && view_eos) begin
            cnt_in     = 3'd0;
            valid_in   = 1'b1;
            prev_hs_in = 1'b0;
         end
         out_in.codepoint    = cp;
         out_in.byte_count   = used;
         out_in.malformed    = bad;
         out_in.string_valid = vflag;
         out_in.string_end   = is_last && view_eos;
         out_in.last_of_run  = is_last;
         out_vld_in          = 1'b1;
      end else if (take) begin
         for (int j = 0; j < PendDepth; j++) pend_in[j] = view[j];
         cnt_in  = view_cnt;
         busy_in = can_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 3'd0;
         eos_ff     <= 1'b0;
         busy_ff    <= 1'b0;
         valid_ff   <= 1'b1;
         prev_hs_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         eos_ff     <= eos_in;
         busy_ff    <= busy_in;
         valid_ff   <= valid_in;
         prev_hs_ff <= prev_hs_in;
         out_vld_ff <= out_vld_in;
      end
      for (int j = 0; j < PendDepth; j++) pend_ff[j] <= pend_in[j];
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

endmodule

FILE: rtl/utf8_stream_decoder_validator_core.sv
// ============================================================================
// utf8_stream_decoder_validator_core - UTF-8 / WTF-8 stream decoder
// Decodes a byte stream into code points with error replacement and keeps a
// per-string validity flag.
// ============================================================================
//
//  Channel | Dir | Ports                     | Word
//  --------+-----+---------------------------+---------------------------------
//  req     | in  | tvalid tready tdata tlast | one string byte, tlast = end
//  rsp     | out | tvalid tready tdata tuser | one decode result, tlast = end
//          |     | tlast                     | of string, tuser = malformed
//  csr     | in  | wr_en wr_data             | validation mode (0 UTF-8, 1 WTF-8)
//
//  A byte yields zero or one result, or flushes k results (errors, end of
//  string). The decoder retires one head sequence per cycle while rsp is not
//  stalled, and takes no new byte until a flush is through. A result passes
//  through the input register, the queue and the result register on its
//  way to rsp.
//  A four-word queue lets the input side keep taking bytes while the decoder
//  works through a multi-result flush or while rsp is stalled.
//  Reset is synchronous; mode resets to strict UTF-8, validity to one.
//
module utf8_stream_decoder_validator_core
   import u8dv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [20:0] codepoint, [23:21] byte_count,
                                    // [24] string_valid, [25] last_of_run,
                                    // [31:26] zero
   output logic        rsp_tuser,   // malformed
   output logic        rsp_tlast,   // string_end
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic            mode_ff, mode_in;
   logic            push_valid, push_ready;
   u8dv_item_type   push_item;
   logic            pop_valid, pop_en;
   u8dv_item_type   pop_item;
   u8dv_result_type rsp_word;

   // Mode register, written only while the block is idle: the user must keep to this, the block does not enforce it
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UTF8;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Front: accept and classify bytes
   u8dv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // Queue between front and decoder
   u8dv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_en     (pop_en)
   );

   // Back: pending window, decode, validity, result register
   u8dv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_en    (pop_en),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_word  (rsp_word)
   );

   // Result word packing
   assign rsp_tdata = {6'd0, rsp_word.last_of_run, rsp_word.string_valid,
                       rsp_word.byte_count, rsp_word.codepoint};
   assign rsp_tuser = rsp_word.malformed;
   assign rsp_tlast = rsp_word.string_end;

endmodule

FILE: rtl/u8dv_checker.sv
// ============================================================================
// u8dv_checker - port level checks
// Watches the result channel of the decoder core.
// ============================================================================
module u8dv_checker
   import u8dv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // Consumed count is 1..4
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:21] != 3'd0) && (rsp_tdata[23:21] <= 3'd4))
      else $error("byte_count out of range");

   // Malformed gives the replacement and clears validity
   a_malformed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[20:0] == CP_REPL) && !rsp_tdata[24])
      else $error("malformed result without replacement");

   // End of string also ends the run; no code point past the limit
   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[25])
      else $error("string end without last of run");

   a_cp_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20:0] <= CP_MAX))
      else $error("code point above limit");

endmodule

bind utf8_stream_decoder_validator_core u8dv_checker u_u8dv_checker (.*);

FILE: tb/utf8_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_checker - result predictor and comparator
// Watches the byte, result and csr channels of the UTF-8 / WTF-8 decoder,
// predicts the result words of every accepted byte and compares them in order.
// ----------------------------------------------------------------------------
module utf8_decode_checker
   import u8dv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          fail_count,
   output int          outstanding
);

   // decoder state as seen from outside
   logic [7:0]      held [4];
   int              held_count;
   logic            after_high;
   logic            string_ok;
   logic            mode_sel;
   u8dv_result_type expected_results [$];

   function automatic logic [2:0] seq_length(input logic [7:0] b);
      casez (b)
         8'b0???????: return LEN_1;
         8'b110?????: return LEN_2;
         8'b1110????: return LEN_3;
         8'b11110???: return LEN_4;
         default:     return LEN_BAD;
      endcase
   endfunction

   // head sequence is complete here; stops at the first bad continuation
   task automatic decode_head(input logic [2:0] len, output logic [20:0] cp,
                              output logic bad, output int used);
      logic [31:0] v;
      v = (len == LEN_1) ? 32'(held[0]) :
          (len == LEN_2) ? 32'(held[0] & 8'h1F) :
          (len == LEN_3) ? 32'(held[0] & 8'h0F) : 32'(held[0] & 8'h07);
      bad = 1'b0;
      used = int'(len);
      for (int i = 1; i < int'(len); i++) begin
         if (!bad) begin
            if (held[i][7:6] != 2'b10) begin
               bad = 1'b1;
               used = i;
            end else begin
               v = {v[25:0], held[i][5:0]};
            end
         end
      end
      if (!bad && ((len == LEN_2 && v < 32'(CP_MIN_2B)) ||
                   (len == LEN_3 && v < 32'(CP_MIN_3B)) ||
                   (len == LEN_4 && v < 32'(CP_MIN_4B)) || v > 32'(CP_MAX)))
         bad = 1'b1;
      cp = bad ? CP_REPL : v[20:0];
   endtask

   task automatic predict_byte(input logic [7:0] din, input logic last);
      u8dv_result_type outs [4];
      u8dv_result_type r;
      logic [2:0]      len;
      logic [20:0]     cp;
      logic            bad;
      logic            stop;
      int              used;
      int              n;
      n = 0;
      stop = 1'b0;
      if (held_count > 3) held_count = 0;
      held[held_count] = din;
      held_count++;
      while (held_count > 0 && n < 4 && !stop) begin
         len = seq_length(held[0]);
         if (len != LEN_BAD && int'(len) > held_count && !last) begin
            stop = 1'b1;   // incomplete, wait for more bytes
         end else begin
            if (len == LEN_BAD || int'(len) > held_count) begin
               cp = CP_REPL;
               bad = 1'b1;
               used = 1;
            end else begin
               decode_head(len, cp, bad, used);
            end
            if (bad)
               string_ok = 1'b0;
            else if (mode_sel == MODE_UTF8 && cp >= CP_SUR_LO && cp <= CP_SUR_HI)
               string_ok = 1'b0;
            else if (mode_sel == MODE_WTF8 && after_high &&
                     cp >= CP_LSUR_LO && cp <= CP_SUR_HI)
               string_ok = 1'b0;
            after_high = !bad && cp >= CP_SUR_LO && cp <= CP_HSUR_HI;
            r.codepoint    = cp;
            r.byte_count   = used[2:0];
            r.malformed    = bad;
            r.string_valid = string_ok;
            r.string_end   = 1'b0;
            r.last_of_run  = 1'b0;
            outs[n] = r;
            n++;
            if (used > held_count) used = held_count;
            for (int i = 0; i < 4; i++)
               held[i] = (i + used < 4) ? held[i + used] : 8'h00;
            held_count -= used;
         end
      end
      if (n > 0) begin
         outs[n - 1].last_of_run = 1'b1;
         if (last) outs[n - 1].string_end = 1'b1;
      end
      if (last) begin
         held_count = 0;
         string_ok = 1'b1;
         after_high = 1'b0;
      end
      for (int i = 0; i < n; i++) expected_results.push_back(outs[i]);
   endtask

   function automatic logic field_ok(input string name, input logic [20:0] want,
                                     input logic [20:0] got);
      if (got !== want)
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      return got === want;
   endfunction

   task automatic check_result();
      u8dv_result_type want;
      logic            wrong;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected word, expected none actual cp %0h tdata %0h",
                  $time, rsp_tdata[20:0], rsp_tdata);
         fail_count <= fail_count + 1;
      end else begin
         want = expected_results.pop_front();
         wrong = 1'b0;
         wrong |= !field_ok("codepoint", want.codepoint, rsp_tdata[20:0]);
         wrong |= !field_ok("byte_count", 21'(want.byte_count), 21'(rsp_tdata[23:21]));
         wrong |= !field_ok("malformed", 21'(want.malformed), 21'(rsp_tuser));
         wrong |= !field_ok("string_valid", 21'(want.string_valid), 21'(rsp_tdata[24]));
         wrong |= !field_ok("string_end", 21'(want.string_end), 21'(rsp_tlast));
         wrong |= !field_ok("last_of_run", 21'(want.last_of_run), 21'(rsp_tdata[25]));
         if (wrong) fail_count <= fail_count + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         after_high = 1'b0;
         string_ok = 1'b1;
         mode_sel = MODE_UTF8;
         for (int i = 0; i < 4; i++) held[i] = 8'h00;
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) mode_sel = csr_wr_data;
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      outstanding <= expected_results.size();
   end

endmodule

FILE: tb/utf8_stream_decoder_validator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_validator_core_test - decoder testbench top
// Drives strings of bytes into the decoder under both validation modes: a
// directed set of edge cases, then random well-formed, broken and noise
// sequences with random idle and stall on both sides. The checker predicts
// and compares every result word; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_validator_core_test;
   import u8dv_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;    // end_of_string
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [20:0] codepoint, [23:21] byte_count,
                              // [24] string_valid, [25] last_of_run
   logic        rsp_tuser;    // malformed
   logic        rsp_tlast;    // string_end
   logic        csr_wr_en;
   logic        csr_wr_data;
   int          fail_count;
   int          outstanding;

   // stimulus bookkeeping
   int          bytes_sent;
   logic        req_fast;     // no idle between input words
   logic        rsp_fast;     // no stall on result words
   logic [7:0]  piece [8];    // bytes of the sequence being built
   int          piece_len;

   utf8_stream_decoder_validator_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   utf8_decode_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the run hangs.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: before each word draw a random stall, then hold
   // tready until a word is taken. rsp_fast flips now and then so that long
   // stretches run at full rate.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      rsp_fast   = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 11) == 0) rsp_fast <= !rsp_fast;
         stall = rsp_fast ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // One input word. The idle gap comes first, so tvalid is only lowered in a
   // step other than the one where it goes high again.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic add(input logic [7:0] b);
      piece[piece_len] = b;
      piece_len++;
   endtask

   // sends the built sequence, end of string on its last byte if asked
   task automatic send_piece(input logic last);
      for (int i = 0; i < piece_len; i++) send_byte(piece[i], last && i == piece_len - 1);
      piece_len = 0;
   endtask

   function automatic logic [7:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   // well-formed UTF-8 encoding of a code point
   task automatic add_cp(input logic [20:0] cp);
      if (cp < CP_MIN_2B) begin
         add(cp[7:0]);
      end else if (cp < CP_MIN_3B) begin
         add({3'b110, cp[10:6]});
         add({2'b10, cp[5:0]});
      end else if (cp < CP_MIN_4B) begin
         add({4'b1110, cp[15:12]});
         add({2'b10, cp[11:6]});
         add({2'b10, cp[5:0]});
      end else begin
         add({5'b11110, cp[20:18]});
         add({2'b10, cp[17:12]});
         add({2'b10, cp[11:6]});
         add({2'b10, cp[5:0]});
      end
   endtask

   // One random sequence: mostly well-formed code points, the rest noise,
   // cut-off sequences and overlong / out-of-range forms.
   task automatic send_random_piece();
      int          pick;
      int          len;
      logic [7:0]  b;
      logic [20:0] cp;
      logic        cut;
      logic        last;
      pick = $urandom_range(0, 99);
      cut = 1'b0;
      if (pick < 60) begin
         case ($urandom_range(1, 4))
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: cp = ($urandom_range(0, 3) == 0) ? 21'($urandom_range('hD800, 'hDFFF))
                                                 : 21'($urandom_range('h800, 'hFFFF));
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
         endcase
         add_cp(cp);
         // high surrogate straight into a low one
         if ($urandom_range(0, 7) == 0) begin
            add_cp(21'($urandom_range('hD800, 'hDBFF)));
            add_cp(21'($urandom_range('hDC00, 'hDFFF)));
         end
      end else if (pick < 75) begin
         add(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
         // lead plus too few continuations, usually followed by a non-continuation
         len = $urandom_range(2, 4);
         b = 8'($urandom);
         case (len)
            2:       add({3'b110, b[4:0]});
            3:       add({4'b1110, b[3:0]});
            default: add({5'b11110, b[2:0]});
         endcase
         repeat ($urandom_range(0, len - 2)) add(cont_byte());
         cut = ($urandom_range(0, 3) == 0);
         if (!cut) begin
            b = 8'($urandom);
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            add(b);
         end
      end else begin
         case ($urandom_range(0, 4))
            0: begin   // overlong two-byte
               add({7'b1100000, 1'($urandom)});
               add(cont_byte());
            end
            1: begin   // overlong three-byte
               add(8'hE0);
               add({3'b100, 5'($urandom)});
               add(cont_byte());
            end
            2: begin   // overlong four-byte
               add(8'hF0);
               add({4'b1000, 4'($urandom)});
               add(cont_byte());
               add(cont_byte());
            end
            3: begin   // just above the code point limit
               add(8'hF4);
               add(8'($urandom_range('h90, 'hBF)));
               add(cont_byte());
               add(cont_byte());
            end
            default: begin   // far above the limit
               add(8'($urandom_range('hF5, 'hF7)));
               repeat (3) add(cont_byte());
            end
         endcase
      end
      last = cut ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) req_fast = !req_fast;
      send_piece(last);
   endtask

   // random bytes, then a closing ASCII byte that ends the string
   task automatic random_phase(input int count);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < count) send_random_piece();
      send_byte(8'($urandom_range(0, 127)), 1'b1);
   endtask

   // Stop sending and let every expected word come back. A trailing byte may
   // still sit in the pipe with no result, so wait on once nothing is outstanding.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = MODE_UTF8;
      req_fast    = 1'b0;
      bytes_sent  = 0;
      piece_len   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- strict UTF-8, directed edge cases ---
      write_mode(MODE_UTF8);
      add(8'h00);                                   // lowest ASCII
      add(8'hC2); add(8'h80);                       // smallest two-byte
      add(8'hEF); add(8'hBF); add(8'hBD);           // a real U+FFFD, stays valid
      add(8'hF4); add(8'h8F); add(8'hBF); add(8'hBF);  // U+10FFFF
      send_piece(1'b1);
      add(8'h80);                                   // continuation as lead
      add(8'hC0); add(8'h80);                       // overlong
      add(8'hE2); add(8'h41); add(8'h7F);           // missing continuation, 3 words
      add(8'hF4); add(8'h90); add(8'h80); add(8'h80);  // above U+10FFFF
      send_piece(1'b1);
      // bad continuation, then three truncated leads flushed: four words
      add(8'hF1); add(8'hF1); add(8'hF1); add(8'hF1);
      send_piece(1'b1);
      drain();

      // --- WTF-8: surrogate pair, then random ---
      write_mode(MODE_WTF8);
      add(8'hED); add(8'hA0); add(8'h80);           // high surrogate alone is fine
      add(8'hED); add(8'hB0); add(8'h80);           // low right after breaks it
      send_piece(1'b1);
      random_phase(25);
      drain();

      // --- strict UTF-8, random ---
      write_mode(MODE_UTF8);
      random_phase(25);
      drain();

      // --- WTF-8 again, random ---
      write_mode(MODE_WTF8);
      random_phase(25);
      drain();

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
